/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the LMS adaptive FIR.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LMSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LMS FIR check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LMSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LMS FIR check failed");

`endif

/* hdl/lmsf_pkg.sv */
// Package with the widths, constants and shared types of the LMS adaptive FIR.
package lmsf_pkg;

    localparam int TAPS_DEFAULT = 8;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int STEP_W   = 16;

    // Weight times sample, Q4.20 by Q1.15.
    localparam int PROD_W   = WEIGHT_W + SAMPLE_W;
    // Step size (unsigned, one zero bit added) times error.
    localparam int MUE_W    = STEP_W + 1 + SAMPLE_W;
    // Scaled error times sample.
    localparam int STEP_P_W = MUE_W + SAMPLE_W;

    // Error goes from Q.35 to Q.15; weight step goes from Q.46 (times two) to Q.20.
    localparam int ERR_SHIFT  = 20;
    localparam int STEP_SHIFT = 25;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Per-phase enables that the controller hands to every cell.
    typedef struct packed {
        logic shift_en;
        logic prod_en;
        logic sum_en;
        logic step_en;
        logic upd_en;
    } cell_ctrl_t;

endpackage

/* hdl/lms_adaptive_fir_top.sv */
// Top level of the LMS adaptive FIR: tap cell chain, controller and output register.
//
// Usage. The input channel carries one word per sample pair (ref_sample and
// desired_sample, both signed Q1.15) under in_valid / in_stall. The output
// channel carries one error_sample word (signed Q1.15, saturated) under
// out_valid / out_stall. A word moves at a rising edge with valid high and
// stall low. The step size mu (unsigned Q0.16) is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. The first TAPS input words
// only fill the delay line: each is taken while the block stays idle and gives
// no output word. After that, each input word gives one error word, loaded
// into the output register after the product, the chained sum and the error
// step, and the block takes the next input word only after the scaling, step
// and weight update steps are done. During the chained sum the partial sum
// walks down the cell chain one cell per cycle.
// Reset clears the delay line, the weights, the warmup count and the output
// valid, and loads the default step size. A stalled output word holds; the
// next error waits in the controller until the output register is free.
module lms_adaptive_fir_top
    import lmsf_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] ref_sample,
    input  logic signed [SAMPLE_W-1:0] desired_sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] error_sample,
    input  logic                       cfg_wr_en,
    input  logic        [STEP_W-1:0]   cfg_wr_data
);

    // The sum of TAPS products needs log2(TAPS) guard bits; one more bit covers
    // the subtraction from the desired sample.
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int DIFF_W = ACC_W + 1;
    localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int WARM_W = $clog2(TAPS + 1);

    localparam logic signed [DIFF_W-1:0] ERR_HALF = DIFF_W'(1) <<< (ERR_SHIFT - 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PROD  = 7'b0000010,
        ST_SUM   = 7'b0000100,
        ST_ERR   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_STEP  = 7'b0100000,
        ST_UPD   = 7'b1000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic        [CNT_W-1:0]    cnt_reg;
    logic        [CNT_W-1:0]    cnt_next;
    logic        [WARM_W-1:0]   warm_reg;
    logic        [WARM_W-1:0]   warm_next;
    logic        [STEP_W-1:0]   step_size_reg;
    logic signed [SAMPLE_W-1:0] d_reg;
    logic signed [SAMPLE_W-1:0] e_reg;
    logic signed [MUE_W-1:0]    mu_e_reg;
    logic signed [MUE_W-1:0]    mu_e_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] error_sample_reg;

    logic                       accept;
    logic                       warm_done;
    logic                       out_free;
    logic                       err_load;
    cell_ctrl_t                 ctrl;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   e_full;
    logic signed [SAMPLE_W-1:0] e_sat;

    // Sample and partial-sum links between neighboring cells.
    logic signed [SAMPLE_W-1:0] x_chain    [TAPS];
    logic signed [ACC_W-1:0]    psum_chain [TAPS+1];

    // The block takes a word only while the controller has nothing in flight.
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign warm_done = (warm_reg == WARM_W'(TAPS));
    assign out_free  = !out_valid_reg || !out_stall;
    assign err_load  = (state_reg == ST_ERR) && out_free;

    assign out_valid    = out_valid_reg;
    assign error_sample = error_sample_reg;

    // Every cell sees the same phase enables; only the data differs per cell.
    assign ctrl.shift_en = accept;
    assign ctrl.prod_en  = (state_reg == ST_PROD);
    assign ctrl.sum_en   = (state_reg == ST_SUM);
    assign ctrl.step_en  = (state_reg == ST_STEP);
    assign ctrl.upd_en   = (state_reg == ST_UPD);

    assign x_chain[0]    = ref_sample;
    assign psum_chain[0] = '0;

    genvar k;
    generate
        for (k = 0; k < TAPS; k++)
        begin : g_cell
            if (k < TAPS - 1)
            begin : g_mid
                lmsf_cell #(
                    .ACC_W (ACC_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .x_in     (x_chain[k]),
                    .x_out    (x_chain[k+1]),
                    .psum_in  (psum_chain[k]),
                    .psum_out (psum_chain[k+1]),
                    .mu_e     (mu_e_reg)
                );
            end
            else
            begin : g_last
                lmsf_cell #(
                    .ACC_W (ACC_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .x_in     (x_chain[k]),
                    .x_out    (),
                    .psum_in  (psum_chain[k]),
                    .psum_out (psum_chain[k+1]),
                    .mu_e     (mu_e_reg)
                );
            end
        end
    endgenerate

    // Error: move d to Q.35, subtract the filter sum, round half up to Q.15 and
    // saturate. The value fits when all bits from the Q.15 sign upward agree.
    always_comb
    begin
        diff   = (DIFF_W'(d_reg) <<< ERR_SHIFT) - DIFF_W'(psum_chain[TAPS]) + ERR_HALF;
        e_full = diff >>> ERR_SHIFT;
        if ((&e_full[DIFF_W-1:SAMPLE_W-1]) || !(|e_full[DIFF_W-1:SAMPLE_W-1]))
        begin
            e_sat = e_full[SAMPLE_W-1:0];
        end
        else
        begin
            e_sat = e_full[DIFF_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    // mu is unsigned, so it gets a zero sign bit before the signed multiply.
    assign mu_e_next = $signed({1'b0, step_size_reg}) * e_reg;

    // Controller. Warmup words only shift the delay line. A full word walks
    // through product, chained summation (one cell per cycle), error, scaling,
    // per-cell step product and weight update.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        warm_next  = warm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (warm_done)
                    begin
                        state_next = ST_PROD;
                    end
                    else
                    begin
                        warm_next = warm_reg + WARM_W'(1);
                    end
                end
            end
            ST_PROD:
            begin
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is loaded only when it is empty or being emptied,
    // so a stalled word is never overwritten.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (err_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            warm_reg      <= '0;
            step_size_reg <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            warm_reg      <= warm_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                step_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg <= desired_sample;
        end
        if (err_load)
        begin
            e_reg            <= e_sat;
            error_sample_reg <= e_sat;
        end
        if (state_reg == ST_SCALE)
        begin
            mu_e_reg <= mu_e_next;
        end
    end

endmodule

/* hdl/lmsf_cell.sv */
// One tap cell: delay-line sample, weight, product, partial sum and weight update.
module lmsf_cell
    import lmsf_pkg::*;
#(
    parameter int ACC_W = PROD_W + 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] x_in,
    output logic signed [SAMPLE_W-1:0] x_out,
    input  logic signed [ACC_W-1:0]    psum_in,
    output logic signed [ACC_W-1:0]    psum_out,
    input  logic signed [MUE_W-1:0]    mu_e
);

    localparam logic signed [STEP_P_W-1:0] STEP_HALF = STEP_P_W'(1) <<< (STEP_SHIFT - 1);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [WEIGHT_W-1:0] w_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    psum_reg;
    logic signed [ACC_W-1:0]    psum_next;
    logic signed [STEP_P_W-1:0] p_reg;
    logic signed [STEP_P_W-1:0] p_next;
    logic signed [STEP_P_W-1:0] p_round;
    logic signed [STEP_P_W-1:0] delta_full;
    logic        [WEIGHT_W:0]   w_sum;

    assign x_out    = x_reg;
    assign psum_out = psum_reg;

    always_comb
    begin
        prod_next  = w_reg * x_reg;
        psum_next  = psum_in + ACC_W'(prod_reg);
        p_next     = mu_e * x_reg;
        p_round    = p_reg + STEP_HALF;
        delta_full = p_round >>> STEP_SHIFT;
        w_sum      = {w_reg[WEIGHT_W-1], w_reg} + delta_full[WEIGHT_W:0];
        if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1])
        begin
            w_next = w_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                     : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        else
        begin
            w_next = w_sum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            w_reg <= '0;
        end
        else
        begin
            if (ctrl.shift_en)
            begin
                x_reg <= x_in;
            end
            if (ctrl.upd_en)
            begin
                w_reg <= w_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.sum_en)
        begin
            psum_reg <= psum_next;
        end
        if (ctrl.step_en)
        begin
            p_reg <= p_next;
        end
    end

endmodule

/* hdl/lmsf_checker.sv */
// Port-level checker for the LMS adaptive FIR and its bind to the top level.
`include "assert_macros.svh"

module lmsf_checker
    import lmsf_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] error_sample
);

    // A stalled output word stays valid and unchanged.
    `LMSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(error_sample))

    // An error word never appears in the cycle right after an input word is taken.
    `LMSF_ASSERT_NEXT(a_no_instant_out, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

    // A new error word is produced only while the block is busy with its input.
    `LMSF_ASSERT_NOW(a_out_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind lms_adaptive_fir_top lmsf_checker u_lmsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .error_sample (error_sample)
);
